// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/lruc_pkg.sv =====
// ---------------------------------------------------------------------------
// lruc_pkg
// Types, codes and constants of the reference-counted LRU cache.
// ---------------------------------------------------------------------------
`default_nettype none

package lruc_pkg;

    localparam int ENTRIES_DEF     = 32;
    localparam int KEY_BITS_DEF    = 64;
    localparam int CHARGE_BITS_DEF = 24;

    localparam int MAX_IDX_W = 10;
    localparam int SLOT_W    = 5;
    localparam int HANDLE_W  = 5;
    localparam int USAGE_W   = 32;
    localparam int REFS_W    = 8;
    localparam int PADDR_W   = 3;

    localparam logic [REFS_W-1:0]  INIT_REFS = 8'd2;
    localparam logic [REFS_W-1:0]  REFS_MAX  = 8'd255;
    localparam logic [USAGE_W-1:0] CAP_RESET = 32'd1048576;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_LOOKUP  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_ERASE   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        KIND_INSERTED   = 4'd0,
        KIND_NO_SLOT    = 4'd1,
        KIND_HIT        = 4'd2,
        KIND_MISS       = 4'd3,
        KIND_RELEASED   = 4'd4,
        KIND_ERASED     = 4'd5,
        KIND_ERASE_MISS = 4'd6,
        KIND_FREED      = 4'd7,
        KIND_BAD_HANDLE = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REPL,
        ST_EVICT,
        ST_INS_OUT,
        ST_FREE
    } t_state;

    typedef enum logic [2:0] {
        SRC_FF,
        SRC_MT,
        SRC_OLD,
        SRC_HDL,
        SRC_FSEL
    } t_src;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ALLOC,
        CMD_UNLINK,
        CMD_TOUCH,
        CMD_RELEASE,
        CMD_FREE
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [MAX_IDX_W-1:0] tgt;
        logic [MAX_IDX_W-1:0] shift_rank;
        logic                 shift;
        logic [MAX_IDX_W-1:0] new_rank;
        logic                 push;
        logic [MAX_IDX_W-1:0] seq;
        logic [MAX_IDX_W-1:0] fsel_seq;
        logic                 skip_en;
        logic [MAX_IDX_W-1:0] skip;
    } t_cell_cmd;

    typedef struct packed {
        logic ff_first;
        logic mt_first;
        logic oldest;
        logic fsel;
        logic alloc;
        logic linked;
    } t_cell_flags;

endpackage

`default_nettype wire

// ===== design/refcounted_lru_cache_with_charge.sv =====
// ---------------------------------------------------------------------------
// refcounted_lru_cache_with_charge
// LRU cache shard with reference counts, charge-based eviction and a row of
// slot cells.
// ---------------------------------------------------------------------------
// Requests enter on i_valid/o_stall (insert, lookup, release, erase); each
// gives one or more results on o_valid/i_stall, the final one flagged o_last.
// One request is in flight at a time; o_stall is high from acceptance until
// its last result has been loaded into the output register.
// Lookup, release and erase end in ST_DECIDE, plus ST_FREE when an entry
// is freed. An insert steps through ST_DECIDE, ST_REPL, ST_EVICT (again per
// eviction), ST_INS_OUT and ST_FREE per freed entry. Each unlink or eviction
// is one command to the row, one per cycle; while the receiver stalls, the
// output register holds its item and the sequencer waits before issuing the
// next result. The capacity register is written over the APB port (address
// 0); the user must write it only while idle, the block does not enforce it.
// Reset empties every slot, clears usage and sets capacity to 1048576.
// ---------------------------------------------------------------------------
`default_nettype none

module refcounted_lru_cache_with_charge #(
    parameter int ENTRIES     = lruc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = lruc_pkg::KEY_BITS_DEF,
    parameter int CHARGE_BITS = lruc_pkg::CHARGE_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [1:0]                     i_req_type,
    input  wire  [KEY_BITS-1:0]            i_key,
    input  wire  [CHARGE_BITS-1:0]         i_charge,
    input  wire  [lruc_pkg::HANDLE_W-1:0]  i_handle,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [3:0]                     o_result_kind,
    output logic [lruc_pkg::SLOT_W-1:0]    o_slot,
    output logic [KEY_BITS-1:0]            o_freed_key,
    output logic                           o_last,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [lruc_pkg::PADDR_W-1:0]   paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MW    = lruc_pkg::MAX_IDX_W;

    lruc_pkg::t_state                r_state, n_state;
    lruc_pkg::t_req                  r_req;
    logic [KEY_BITS-1:0]             r_key;
    logic [CHARGE_BITS-1:0]          r_charge;
    logic [lruc_pkg::HANDLE_W-1:0]   r_handle;
    logic [IDX_W-1:0]                r_slot, n_slot;
    logic [lruc_pkg::USAGE_W-1:0]    r_usage, n_usage;
    logic [lruc_pkg::USAGE_W-1:0]    r_cap;
    logic [CNT_W-1:0]                r_lcount, n_lcount;
    logic [CNT_W-1:0]                r_fcount, n_fcount;

    logic                            r_out_valid, n_out_valid;
    lruc_pkg::t_kind                 r_out_kind, n_out_kind;
    logic [lruc_pkg::SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic [KEY_BITS-1:0]             r_out_key, n_out_key;
    logic                            r_out_last, n_out_last;

    lruc_pkg::t_cell_cmd             cmd;
    lruc_pkg::t_cell_flags           flags [ENTRIES];
    logic [lruc_pkg::REFS_W-1:0]     c_refs [ENTRIES];
    logic [IDX_W-1:0]                c_rank [ENTRIES];
    logic [CHARGE_BITS-1:0]          c_charge [ENTRIES];
    logic [KEY_BITS-1:0]             c_key [ENTRIES];
    logic [ENTRIES:0]                ff_chain;
    logic [ENTRIES:0]                mt_chain;

    lruc_pkg::t_src                  src;
    logic [ENTRIES-1:0]              sel_oh;
    logic                            hdl_in_range;
    logic                            tgt_found;
    logic [IDX_W-1:0]                tgt_idx;
    logic [lruc_pkg::REFS_W-1:0]     tgt_refs;
    logic [IDX_W-1:0]                tgt_rank;
    logic [CHARGE_BITS-1:0]          tgt_charge;
    logic [KEY_BITS-1:0]             tgt_key;
    logic                            tgt_alloc;
    logic                            tgt_linked;
    logic                            zero_after;
    logic                            can_emit;
    logic                            accept;
    logic                            cfg_wr;

    assign accept   = i_valid && (r_state == lruc_pkg::ST_IDLE);
    assign o_stall  = (r_state != lruc_pkg::ST_IDLE);
    assign can_emit = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_slot        = r_out_slot;
    assign o_freed_key   = r_out_key;
    assign o_last        = r_out_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == lruc_pkg::REG_CAPACITY) ? r_cap : '0;

    // ---- row of slot cells ----
    assign ff_chain[0] = 1'b0;
    assign mt_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lruc_cell #(
            .ENTRIES     (ENTRIES),
            .KEY_BITS    (KEY_BITS),
            .CHARGE_BITS (CHARGE_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_key      (r_key),
            .i_charge   (r_charge),
            .i_ff_chain (ff_chain[g]),
            .o_ff_chain (ff_chain[g+1]),
            .i_mt_chain (mt_chain[g]),
            .o_mt_chain (mt_chain[g+1]),
            .o_flags    (flags[g]),
            .o_refs     (c_refs[g]),
            .o_rank     (c_rank[g]),
            .o_charge   (c_charge[g]),
            .o_key      (c_key[g])
        );
    end

    // ---- pick the cell this cycle works on ----
    assign hdl_in_range = (32'(r_handle) < 32'(ENTRIES));

    always_comb begin
        unique case (r_state)
            lruc_pkg::ST_REPL:  src = lruc_pkg::SRC_MT;
            lruc_pkg::ST_EVICT: src = lruc_pkg::SRC_OLD;
            lruc_pkg::ST_FREE:  src = lruc_pkg::SRC_FSEL;
            default: begin
                case (r_req) inside
                    lruc_pkg::REQ_INSERT:                      src = lruc_pkg::SRC_FF;
                    lruc_pkg::REQ_LOOKUP, lruc_pkg::REQ_ERASE: src = lruc_pkg::SRC_MT;
                    default:                                   src = lruc_pkg::SRC_HDL;
                endcase
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            unique case (src)
                lruc_pkg::SRC_FF:   sel_oh[i] = flags[i].ff_first;
                lruc_pkg::SRC_MT:   sel_oh[i] = flags[i].mt_first;
                lruc_pkg::SRC_OLD:  sel_oh[i] = flags[i].oldest;
                lruc_pkg::SRC_FSEL: sel_oh[i] = flags[i].fsel;
                default: sel_oh[i] = hdl_in_range && (IDX_W'(r_handle) == IDX_W'(i));
            endcase
        end
    end

    always_comb begin
        tgt_found  = 1'b0;
        tgt_idx    = '0;
        tgt_refs   = '0;
        tgt_rank   = '0;
        tgt_charge = '0;
        tgt_key    = '0;
        tgt_alloc  = 1'b0;
        tgt_linked = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_oh[i]) begin
                tgt_found  = 1'b1;
                tgt_idx    = tgt_idx | IDX_W'(i);
                tgt_refs   = tgt_refs | c_refs[i];
                tgt_rank   = tgt_rank | c_rank[i];
                tgt_charge = tgt_charge | c_charge[i];
                tgt_key    = tgt_key | c_key[i];
                tgt_alloc  = tgt_alloc | flags[i].alloc;
                tgt_linked = tgt_linked | flags[i].linked;
            end
        end
    end

    assign zero_after = (tgt_refs <= 8'd1);

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_usage     = r_usage;
        n_lcount    = r_lcount;
        n_fcount    = r_fcount;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;

        cmd            = '0;
        cmd.op         = lruc_pkg::CMD_NONE;
        cmd.tgt        = MW'(tgt_idx);
        cmd.shift_rank = MW'(tgt_rank);
        cmd.seq        = MW'(r_fcount);
        cmd.fsel_seq   = MW'(r_fcount - 1'b1);
        cmd.skip_en    = (r_req == lruc_pkg::REQ_INSERT);
        cmd.skip       = MW'(r_slot);

        unique case (r_state)
            lruc_pkg::ST_IDLE: begin
                if (i_valid) n_state = lruc_pkg::ST_DECIDE;
            end

            lruc_pkg::ST_DECIDE: begin
                unique case (r_req)
                    lruc_pkg::REQ_INSERT: begin
                        if (!tgt_found) begin
                            if (can_emit) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = lruc_pkg::KIND_NO_SLOT;
                                n_out_slot  = '0;
                                n_out_key   = '0;
                                n_out_last  = 1'b1;
                                n_state     = lruc_pkg::ST_IDLE;
                            end
                        end else begin
                            cmd.op       = lruc_pkg::CMD_ALLOC;
                            cmd.new_rank = MW'(r_lcount);
                            n_usage      = r_usage + 32'(r_charge);
                            n_lcount     = r_lcount + 1'b1;
                            n_slot       = tgt_idx;
                            n_state      = lruc_pkg::ST_REPL;
                        end
                    end
                    lruc_pkg::REQ_LOOKUP: begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out_key   = '0;
                            n_out_last  = 1'b1;
                            n_state     = lruc_pkg::ST_IDLE;
                            if (tgt_found) begin
                                n_out_kind   = lruc_pkg::KIND_HIT;
                                n_out_slot   = lruc_pkg::SLOT_W'(tgt_idx);
                                cmd.op       = lruc_pkg::CMD_TOUCH;
                                cmd.shift    = 1'b1;
                                cmd.new_rank = MW'(r_lcount - 1'b1);
                            end else begin
                                n_out_kind = lruc_pkg::KIND_MISS;
                                n_out_slot = '0;
                            end
                        end
                    end
                    lruc_pkg::REQ_RELEASE: begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out_key   = '0;
                            n_out_slot  = lruc_pkg::SLOT_W'(r_handle);
                            if (tgt_found && tgt_alloc) begin
                                n_out_kind = lruc_pkg::KIND_RELEASED;
                                n_out_last = !zero_after;
                                cmd.op     = lruc_pkg::CMD_RELEASE;
                                cmd.push   = zero_after;
                                cmd.shift  = zero_after && tgt_linked;
                                if (zero_after) begin
                                    n_fcount = r_fcount + 1'b1;
                                    n_state  = lruc_pkg::ST_FREE;
                                    if (tgt_linked) begin
                                        n_usage  = r_usage - 32'(tgt_charge);
                                        n_lcount = r_lcount - 1'b1;
                                    end
                                end else begin
                                    n_state = lruc_pkg::ST_IDLE;
                                end
                            end else begin
                                n_out_kind = lruc_pkg::KIND_BAD_HANDLE;
                                n_out_last = 1'b1;
                                n_state    = lruc_pkg::ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out_key   = '0;
                            if (tgt_found) begin
                                n_out_kind = lruc_pkg::KIND_ERASED;
                                n_out_slot = lruc_pkg::SLOT_W'(tgt_idx);
                                n_out_last = !zero_after;
                                cmd.op     = lruc_pkg::CMD_UNLINK;
                                cmd.push   = zero_after;
                                cmd.shift  = 1'b1;
                                n_usage    = r_usage - 32'(tgt_charge);
                                n_lcount   = r_lcount - 1'b1;
                                if (zero_after) begin
                                    n_fcount = r_fcount + 1'b1;
                                    n_state  = lruc_pkg::ST_FREE;
                                end else begin
                                    n_state = lruc_pkg::ST_IDLE;
                                end
                            end else begin
                                n_out_kind = lruc_pkg::KIND_ERASE_MISS;
                                n_out_slot = '0;
                                n_out_last = 1'b1;
                                n_state    = lruc_pkg::ST_IDLE;
                            end
                        end
                    end
                endcase
            end

            lruc_pkg::ST_REPL: begin
                // drop an older entry with the same key
                if (tgt_found) begin
                    cmd.op    = lruc_pkg::CMD_UNLINK;
                    cmd.push  = zero_after;
                    cmd.shift = 1'b1;
                    n_usage   = r_usage - 32'(tgt_charge);
                    n_lcount  = r_lcount - 1'b1;
                    if (zero_after) n_fcount = r_fcount + 1'b1;
                end
                n_state = lruc_pkg::ST_EVICT;
            end

            lruc_pkg::ST_EVICT: begin
                if ((r_usage > r_cap) && (r_lcount != '0)) begin
                    cmd.op    = lruc_pkg::CMD_UNLINK;
                    cmd.push  = zero_after;
                    cmd.shift = 1'b1;
                    n_usage   = r_usage - 32'(tgt_charge);
                    n_lcount  = r_lcount - 1'b1;
                    if (zero_after) n_fcount = r_fcount + 1'b1;
                end else begin
                    n_state = lruc_pkg::ST_INS_OUT;
                end
            end

            lruc_pkg::ST_INS_OUT: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = lruc_pkg::KIND_INSERTED;
                    n_out_slot  = lruc_pkg::SLOT_W'(r_slot);
                    n_out_key   = '0;
                    n_out_last  = (r_fcount == '0);
                    n_state     = (r_fcount == '0) ? lruc_pkg::ST_IDLE : lruc_pkg::ST_FREE;
                end
            end

            default: begin
                // report freed entries, latest unlinked first
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = lruc_pkg::KIND_FREED;
                    n_out_slot  = lruc_pkg::SLOT_W'(tgt_idx);
                    n_out_key   = tgt_key;
                    n_out_last  = (r_fcount == CNT_W'(1));
                    cmd.op      = lruc_pkg::CMD_FREE;
                    n_fcount    = r_fcount - 1'b1;
                    if (r_fcount == CNT_W'(1)) n_state = lruc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lruc_pkg::ST_IDLE;
            r_usage     <= '0;
            r_lcount    <= '0;
            r_fcount    <= '0;
            r_cap       <= lruc_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_usage     <= n_usage;
            r_lcount    <= n_lcount;
            r_fcount    <= n_fcount;
            r_out_valid <= n_out_valid;
            if (cfg_wr && (paddr[2] == lruc_pkg::REG_CAPACITY)) r_cap <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= lruc_pkg::t_req'(i_req_type);
            r_key    <= i_key;
            r_charge <= i_charge;
            r_handle <= i_handle;
        end
        r_slot     <= n_slot;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

// ===== design/lruc_cell.sv =====
// ---------------------------------------------------------------------------
// lruc_cell
// One slot of the cache: key, charge, count, recency rank and free mark.
// ---------------------------------------------------------------------------
`default_nettype none

module lruc_cell #(
    parameter int ENTRIES     = lruc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = lruc_pkg::KEY_BITS_DEF,
    parameter int CHARGE_BITS = lruc_pkg::CHARGE_BITS_DEF,
    parameter int CELL_IDX    = 0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire lruc_pkg::t_cell_cmd    i_cmd,
    input  wire  [KEY_BITS-1:0]         i_key,
    input  wire  [CHARGE_BITS-1:0]      i_charge,
    input  wire                         i_ff_chain,
    output logic                        o_ff_chain,
    input  wire                         i_mt_chain,
    output logic                        o_mt_chain,
    output lruc_pkg::t_cell_flags       o_flags,
    output logic [lruc_pkg::REFS_W-1:0] o_refs,
    output logic [$clog2(ENTRIES)-1:0]  o_rank,
    output logic [CHARGE_BITS-1:0]      o_charge,
    output logic [KEY_BITS-1:0]         o_key
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                        r_alloc;
    logic                        r_linked;
    logic                        r_pend;
    logic [KEY_BITS-1:0]         r_key;
    logic [CHARGE_BITS-1:0]      r_charge;
    logic [lruc_pkg::REFS_W-1:0] r_refs;
    logic [IDX_W-1:0]            r_rank;
    logic [IDX_W-1:0]            r_seq;

    logic                        is_tgt;
    logic                        is_skip;
    logic                        do_shift;
    logic                        mt_hit;
    logic [lruc_pkg::REFS_W-1:0] refs_dec;
    logic [lruc_pkg::REFS_W-1:0] refs_inc;

    assign is_tgt   = (i_cmd.tgt[IDX_W-1:0] == IDX_W'(CELL_IDX));
    assign is_skip  = i_cmd.skip_en && (i_cmd.skip[IDX_W-1:0] == IDX_W'(CELL_IDX));
    assign do_shift = i_cmd.shift && r_linked && !is_tgt
                      && (r_rank > i_cmd.shift_rank[IDX_W-1:0]);
    assign refs_dec = (r_refs == '0) ? r_refs : r_refs - 1'b1;
    assign refs_inc = (r_refs == lruc_pkg::REFS_MAX) ? r_refs : r_refs + 1'b1;

    // first free slot and first matching key ripple along the row
    assign mt_hit     = r_linked && (r_key == i_key) && !is_skip;
    assign o_ff_chain = i_ff_chain || !r_alloc;
    assign o_mt_chain = i_mt_chain || mt_hit;

    assign o_flags.ff_first = !r_alloc && !i_ff_chain;
    assign o_flags.mt_first = mt_hit && !i_mt_chain;
    assign o_flags.oldest   = r_linked && (r_rank == '0);
    assign o_flags.fsel     = r_pend && (r_seq == i_cmd.fsel_seq[IDX_W-1:0]);
    assign o_flags.alloc    = r_alloc;
    assign o_flags.linked   = r_linked;

    assign o_refs   = r_refs;
    assign o_rank   = r_rank;
    assign o_charge = r_charge;
    assign o_key    = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc  <= 1'b0;
            r_linked <= 1'b0;
            r_pend   <= 1'b0;
        end else if (is_tgt) begin
            case (i_cmd.op)
                lruc_pkg::CMD_ALLOC: begin
                    r_alloc  <= 1'b1;
                    r_linked <= 1'b1;
                end
                lruc_pkg::CMD_UNLINK: begin
                    r_linked <= 1'b0;
                    if (i_cmd.push) r_pend <= 1'b1;
                end
                lruc_pkg::CMD_RELEASE: begin
                    if (i_cmd.push) begin
                        r_pend   <= 1'b1;
                        r_linked <= 1'b0;
                    end
                end
                lruc_pkg::CMD_FREE: begin
                    r_alloc <= 1'b0;
                    r_pend  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_tgt) begin
            case (i_cmd.op)
                lruc_pkg::CMD_ALLOC: begin
                    r_key    <= i_key;
                    r_charge <= i_charge;
                    r_refs   <= lruc_pkg::INIT_REFS;
                    r_rank   <= i_cmd.new_rank[IDX_W-1:0];
                end
                lruc_pkg::CMD_UNLINK, lruc_pkg::CMD_RELEASE: begin
                    r_refs <= refs_dec;
                    if (i_cmd.push) r_seq <= i_cmd.seq[IDX_W-1:0];
                end
                lruc_pkg::CMD_TOUCH: begin
                    r_refs <= refs_inc;
                    r_rank <= i_cmd.new_rank[IDX_W-1:0];
                end
                default: ;
            endcase
        end else if (do_shift) begin
            r_rank <= r_rank - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/lruc_checker.sv =====
// ---------------------------------------------------------------------------
// lruc_checker
// Port-level checks of the LRU cache, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lruc_checker #(
    parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEF
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_stall,
    input wire                         o_valid,
    input wire                         i_stall,
    input wire [3:0]                   o_result_kind,
    input wire [lruc_pkg::SLOT_W-1:0]  o_slot,
    input wire [KEY_BITS-1:0]          o_freed_key,
    input wire                         o_last
);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_kind) && $stable(o_slot) && $stable(o_last))

    // one request in flight: an accepted item always closes the input
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // single-result kinds always end their request
    `ASSERT_IMP(a_single_last, i_clk, i_rst_n, o_valid && (o_result_kind == lruc_pkg::KIND_NO_SLOT || o_result_kind == lruc_pkg::KIND_HIT || o_result_kind == lruc_pkg::KIND_MISS || o_result_kind == lruc_pkg::KIND_ERASE_MISS || o_result_kind == lruc_pkg::KIND_BAD_HANDLE), o_last)

    `ASSERT_IMP(a_key_only_freed, i_clk, i_rst_n, o_valid && (o_result_kind != lruc_pkg::KIND_FREED), o_freed_key == '0)

endmodule

bind refcounted_lru_cache_with_charge lruc_checker #(.KEY_BITS(KEY_BITS)) u_lruc_checker (.*);

`default_nettype wire

// ===== test/tb_refcounted_lru_cache_with_charge.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_refcounted_lru_cache_with_charge
// Self-checking bench for the reference-counted LRU cache shard.
// ---------------------------------------------------------------------------
// A directed table covers the empty cache, field extremes, replacement,
// eviction and bad handles. Random phases follow at several capacities.
// Every result is checked field by field against a behavioural cache model
// or, for single-result table rows, against the table. Random request gaps
// and random stalls on the result side apply outside calm stretches.
// ---------------------------------------------------------------------------

module tb_refcounted_lru_cache_with_charge;

    localparam int NSLOT     = 32;
    localparam int CYCLE_LIM = 1000000;

    typedef struct {
        lruc_pkg::t_kind kind;
        logic [4:0]      slot;
        logic [63:0]     fkey;
        logic            last;
    } t_res;

    typedef struct {
        lruc_pkg::t_req  rq;
        logic [63:0]     k;
        logic [23:0]     c;
        logic [4:0]      h;
        bit              typed;
        lruc_pkg::t_kind tk;
        logic [4:0]      ts;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_key = '0;
    logic [23:0] i_charge = '0;
    logic [4:0]  i_handle = '0;
    logic        i_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_stall;
    wire         o_valid;
    wire  [3:0]  o_result_kind;
    wire  [4:0]  o_slot;
    wire  [63:0] o_freed_key;
    wire         o_last;
    wire  [31:0] prdata;
    wire         pready;

    refcounted_lru_cache_with_charge u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_key(i_key), .i_charge(i_charge),
        .i_handle(i_handle),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_kind(o_result_kind), .o_slot(o_slot),
        .o_freed_key(o_freed_key), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache model state
    bit          m_alloc [NSLOT];
    bit          m_linked[NSLOT];
    logic [63:0] m_key   [NSLOT];
    logic [23:0] m_charge[NSLOT];
    logic [7:0]  m_refs  [NSLOT];
    logic [4:0]  m_newer [NSLOT];
    logic [4:0]  m_older [NSLOT];
    logic [4:0]  m_oldest, m_newest;
    bit          m_empty;
    logic [31:0] m_usage, m_capacity;

    t_res pending_results[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_items = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    int   stall_left = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
    endtask

    function automatic void model_unlink(int s);
        logic [4:0] o, nw;
        o = m_older[s];
        nw = m_newer[s];
        if (s == m_oldest && s == m_newest) m_empty = 1'b1;
        else if (s == m_oldest) m_oldest = nw;
        else if (s == m_newest) m_newest = o;
        else begin
            m_newer[o] = nw;
            m_older[nw] = o;
        end
        m_linked[s] = 1'b0;
        m_usage = m_usage - 32'(m_charge[s]);
    endfunction

    function automatic void model_append(int s);
        if (m_empty) begin
            m_oldest = 5'(s);
            m_empty = 1'b0;
        end else begin
            m_older[s] = m_newest;
            m_newer[m_newest] = 5'(s);
        end
        m_newest = 5'(s);
        m_linked[s] = 1'b1;
        m_usage = m_usage + 32'(m_charge[s]);
    endfunction

    function automatic bit drop_ref(int s);
        if (m_refs[s] > 0) m_refs[s]--;
        return m_refs[s] == 0;
    endfunction

    function automatic int find_key(logic [63:0] k, int skip);
        for (int i = 0; i < NSLOT; i++)
            if (i != skip && m_linked[i] && m_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void add_res(ref t_res q[$], input lruc_pkg::t_kind kd, input int s,
                                    input logic [63:0] k);
        t_res r;
        r.kind = kd;
        r.slot = 5'(s);
        r.fkey = k;
        r.last = 1'b0;
        q.push_back(r);
    endfunction

    // Compute the results of one request and update the model.
    function automatic void cache_predict(input lruc_pkg::t_req rq, input logic [63:0] k,
                                          input logic [23:0] c, input logic [4:0] h,
                                          ref t_res q[$]);
        int freed[$];
        int s, old;
        s = -1;
        case (rq)
            lruc_pkg::REQ_INSERT: begin
                for (int i = 0; i < NSLOT; i++)
                    if (!m_alloc[i] && s < 0) s = i;
                if (s < 0) begin
                    add_res(q, lruc_pkg::KIND_NO_SLOT, 0, '0);
                end else begin
                    m_alloc[s] = 1'b1;
                    m_key[s] = k;
                    m_charge[s] = c;
                    m_refs[s] = lruc_pkg::INIT_REFS;
                    model_append(s);
                    old = find_key(k, s);
                    if (old >= 0) begin
                        model_unlink(old);
                        if (drop_ref(old)) freed.push_back(old);
                    end
                    while (m_usage > m_capacity && !m_empty) begin
                        old = m_oldest;
                        model_unlink(old);
                        if (drop_ref(old)) freed.push_back(old);
                    end
                    add_res(q, lruc_pkg::KIND_INSERTED, s, '0);
                    for (int i = freed.size() - 1; i >= 0; i--) begin
                        m_alloc[freed[i]] = 1'b0;
                        add_res(q, lruc_pkg::KIND_FREED, freed[i], m_key[freed[i]]);
                    end
                end
            end
            lruc_pkg::REQ_LOOKUP: begin
                s = find_key(k, -1);
                if (s < 0) begin
                    add_res(q, lruc_pkg::KIND_MISS, 0, '0);
                end else begin
                    if (m_refs[s] < lruc_pkg::REFS_MAX) m_refs[s]++;
                    model_unlink(s);
                    model_append(s);
                    add_res(q, lruc_pkg::KIND_HIT, s, '0);
                end
            end
            lruc_pkg::REQ_RELEASE: begin
                if (!m_alloc[h]) begin
                    add_res(q, lruc_pkg::KIND_BAD_HANDLE, h, '0);
                end else begin
                    add_res(q, lruc_pkg::KIND_RELEASED, h, '0);
                    if (drop_ref(h)) begin
                        if (m_linked[h]) model_unlink(h);
                        m_alloc[h] = 1'b0;
                        add_res(q, lruc_pkg::KIND_FREED, h, m_key[h]);
                    end
                end
            end
            default: begin
                s = find_key(k, -1);
                if (s < 0) begin
                    add_res(q, lruc_pkg::KIND_ERASE_MISS, 0, '0);
                end else begin
                    model_unlink(s);
                    add_res(q, lruc_pkg::KIND_ERASED, s, '0);
                    if (drop_ref(s)) begin
                        m_alloc[s] = 1'b0;
                        add_res(q, lruc_pkg::KIND_FREED, s, m_key[s]);
                    end
                end
            end
        endcase
        q[q.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_req(input t_row row);
        t_res res[$];
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= row.rq;
        i_key      <= row.k;
        i_charge   <= row.c;
        i_handle   <= row.h;
        do @(posedge i_clk); while (o_stall);
        n_items++;
        cache_predict(row.rq, row.k, row.c, row.h, res);
        if (row.typed) begin
            // single-result rows: the expectation is written in the table
            if (res.size() != 1) report_mismatch("table row count", res.size(), 1);
            res.delete();
            add_res(res, row.tk, row.ts, '0);
            res[0].last = 1'b1;
        end
        foreach (res[i]) pending_results.push_back(res[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== v) report_mismatch("capacity readback", prdata, v);
        psel <= 1'b0;
        penable <= 1'b0;
        m_capacity = v;
        @(posedge i_clk);
    endtask

    function automatic t_row rand_row();
        t_row row;
        int r, tries;
        r = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.tk = lruc_pkg::KIND_INSERTED;
        row.ts = '0;
        row.rq = (r < 35) ? lruc_pkg::REQ_INSERT : (r < 60) ? lruc_pkg::REQ_LOOKUP :
                 (r < 90) ? lruc_pkg::REQ_RELEASE : lruc_pkg::REQ_ERASE;
        row.k = ($urandom_range(0, 99) < 80) ? 64'($urandom_range(0, 11))
                                             : {$urandom, $urandom};
        r = $urandom_range(0, 99);
        row.c = (r < 70) ? 24'($urandom_range(0, 400)) : (r < 90) ? 24'($urandom) :
                (r < 95) ? 24'h0 : 24'hFFFFFF;
        row.h = 5'($urandom);
        // mostly release slots that are actually held
        if ($urandom_range(0, 99) < 75)
            for (tries = 0; tries < 8 && !m_alloc[row.h]; tries++) row.h = 5'($urandom);
        return row;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i == n / 2) begin
                // hold the sender until the shard has drained
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send_req(rand_row());
        end
        calm = 1'b0;
    endtask

    // result side: random stalls and the scoreboard
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", o_result_kind, want.kind);
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
                if (o_freed_key !== want.fkey)
                    report_mismatch("freed_key", o_freed_key, want.fkey);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
            n_checked++;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:84]:  i_stall <= 1'b0;
                [85:96]: begin i_stall <= 1'b1; stall_left <= $urandom_range(0, 2); end
                default: begin i_stall <= 1'b1; stall_left <= $urandom_range(9, 29); end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIM) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    t_row table_rows[$];

    function automatic t_row mk(lruc_pkg::t_req rq, logic [63:0] k, logic [23:0] c,
                                logic [4:0] h, bit typed = 1'b0,
                                lruc_pkg::t_kind tk = lruc_pkg::KIND_INSERTED,
                                logic [4:0] ts = '0);
        t_row row;
        row.rq = rq; row.k = k; row.c = c; row.h = h;
        row.typed = typed; row.tk = tk; row.ts = ts;
        return row;
    endfunction

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            m_alloc[i] = 0; m_linked[i] = 0; m_key[i] = '0; m_charge[i] = '0;
            m_refs[i] = '0; m_newer[i] = '0; m_older[i] = '0;
        end
        m_oldest = '0; m_newest = '0; m_empty = 1'b1; m_usage = '0;
        m_capacity = lruc_pkg::CAP_RESET;

        table_rows.push_back(mk(lruc_pkg::REQ_LOOKUP, 64'd5, 24'd0, 5'd0, 1,
                                lruc_pkg::KIND_MISS, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_ERASE, 64'd5, 24'd0, 5'd0, 1,
                                lruc_pkg::KIND_ERASE_MISS, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd0, 1,
                                lruc_pkg::KIND_BAD_HANDLE, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, '1, '1, 5'd31, 1,
                                lruc_pkg::KIND_BAD_HANDLE, 5'd31));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'd0, 24'd0, 5'd0, 1,
                                lruc_pkg::KIND_INSERTED, 5'd0));
        // oversized charge evicts everything, the new entry included
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, '1, 24'hFFFFFF, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_LOOKUP, '1, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd1));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'd7, 24'd10, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_LOOKUP, 64'd7, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'd7, 24'd20, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_ERASE, 64'd7, 24'd0, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'd9, 24'h800000, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd2));
        // second release of slot 2, never allocated, is again a bad handle
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd2));
        table_rows.push_back(mk(lruc_pkg::REQ_RELEASE, 64'd0, 24'd0, 5'd1));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'h5555_5555_5555_5555,
                                24'h555555, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA,
                                24'hAAAAAA, 5'd0));
        table_rows.push_back(mk(lruc_pkg::REQ_ERASE, 64'hAAAA_AAAA_AAAA_AAAA,
                                24'd0, 5'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) send_req(table_rows[i]);
        run_random(80);

        wait_drained();
        write_capacity(32'd0);
        run_random(30);

        wait_drained();
        write_capacity(32'd1500);
        run_random(80);

        wait_drained();
        write_capacity(32'hFFFF_FFFF);
        run_random(60);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), 0);
        $display("%0d requests sent, %0d results checked at capacities default/0/1500/max",
                 n_items, n_checked);
        $display("covered insert, lookup, release, erase, replacement and eviction");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lruc_pkg.sv
design/lruc_cell.sv
design/refcounted_lru_cache_with_charge.sv
design/lruc_checker.sv
test/tb_refcounted_lru_cache_with_charge.sv
